FILE: design/ncc_pkg.sv
// Shared types, constants and register codes of the neighbor coordination counter.
`timescale 1ns / 1ps

package ncc_pkg;

	localparam int COLUMNS     = 4;
	localparam int MAX_COUNT   = 1023;
	localparam int NUM_OUT     = 4;
	localparam int FIELD_MAX   = 1023;
	localparam int COUNT_CAP   = (MAX_COUNT < FIELD_MAX) ? MAX_COUNT : FIELD_MAX;
	localparam int COUNT_W     = 10;
	localparam int COORD_W     = 32;
	localparam int TYPE_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int AXES        = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CUTOFF_SQ      = 2'd0,
		CFG_COLUMNS_IN_USE = 2'd1,
		CFG_TYPE_WINDOWS   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic               last;
		logic               cig;
		logic               base_ok;
		logic [NUM_OUT-1:0] col_act;
		logic [NUM_OUT-1:0] col_win;
	} stage_ctl_t;

	typedef struct packed {
		logic               last;
		logic               cig;
		logic [NUM_OUT-1:0] col_act;
		logic [NUM_OUT-1:0] col_en;
	} q_item_t;

	typedef struct packed {
		logic [QLVL_W-1:0] level;
		logic              full;
	} q_stat_t;

endpackage

FILE: design/ncc_if.sv
// Channel interfaces: neighbor items, count results and configuration writes.
`timescale 1ns / 1ps

interface ncc_in_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     center_in_group;
	logic                                     neighbor_valid;
	logic                                     neighbor_in_group;
	logic        [ncc_pkg::TYPE_W-1:0]        neighbor_type;
	logic signed [ncc_pkg::COORD_W-1:0]       center_x;
	logic signed [ncc_pkg::COORD_W-1:0]       center_y;
	logic signed [ncc_pkg::COORD_W-1:0]       center_z;
	logic signed [ncc_pkg::COORD_W-1:0]       neighbor_x;
	logic signed [ncc_pkg::COORD_W-1:0]       neighbor_y;
	logic signed [ncc_pkg::COORD_W-1:0]       neighbor_z;
	logic                                     last_neighbor;

	modport source (
		output valid, center_in_group, neighbor_valid, neighbor_in_group, neighbor_type,
			center_x, center_y, center_z, neighbor_x, neighbor_y, neighbor_z, last_neighbor,
		input  ready
	);
	modport sink (
		input  valid, center_in_group, neighbor_valid, neighbor_in_group, neighbor_type,
			center_x, center_y, center_z, neighbor_x, neighbor_y, neighbor_z, last_neighbor,
		output ready
	);
endinterface

interface ncc_out_if;
	logic                         valid;
	logic                         ready;
	logic [ncc_pkg::COUNT_W-1:0]  count_col0;
	logic [ncc_pkg::COUNT_W-1:0]  count_col1;
	logic [ncc_pkg::COUNT_W-1:0]  count_col2;
	logic [ncc_pkg::COUNT_W-1:0]  count_col3;

	modport source (
		output valid, count_col0, count_col1, count_col2, count_col3,
		input  ready
	);
	modport sink (
		input  valid, count_col0, count_col1, count_col2, count_col3,
		output ready
	);
endinterface

interface ncc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ncc_pkg::CFG_IDX_W-1:0]   index;
	logic [ncc_pkg::CFG_DATA_W-1:0]  data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

FILE: design/ncc_front.sv
// Front end: configuration registers, distance pipeline and type-window classification.
`timescale 1ns / 1ps

module ncc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	ncc_in_if.sink               nbr,
	ncc_cfg_if.sink              cfg,
	output logic                 push_valid,
	output ncc_pkg::q_item_t     push_item,
	input  logic                 push_ready
);

	logic [ncc_pkg::CFG_DATA_W-1:0] cutoff_sq_q;
	logic [2:0]                     columns_in_use_q;
	logic [ncc_pkg::CFG_DATA_W-1:0] type_windows_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_sq_q      <= '0;
			columns_in_use_q <= 3'd1;
			type_windows_q   <= '0;
		end else if (cfg.valid) begin
			case (ncc_pkg::cfg_reg_t'(cfg.index))
				ncc_pkg::CFG_CUTOFF_SQ:      cutoff_sq_q      <= cfg.data;
				ncc_pkg::CFG_COLUMNS_IN_USE: columns_in_use_q <= cfg.data[2:0];
				ncc_pkg::CFG_TYPE_WINDOWS:   type_windows_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	logic [2:0]                   ncols;
	logic [ncc_pkg::NUM_OUT-1:0]  col_act;
	logic [ncc_pkg::NUM_OUT-1:0]  col_win;
	ncc_pkg::stage_ctl_t          ctl_in;

	always_comb begin
		ncols = columns_in_use_q;
		if (ncols == 3'd0)
			ncols = 3'd1;
		if (ncols > 3'(ncc_pkg::COLUMNS))
			ncols = 3'(ncc_pkg::COLUMNS);
		for (int m = 0; m < ncc_pkg::NUM_OUT; m++) begin
			col_act[m] = (m < ncc_pkg::COLUMNS) && (3'(m) < ncols);
			col_win[m] = (nbr.neighbor_type >= type_windows_q[16*m +: 8]) &&
				(nbr.neighbor_type <= type_windows_q[16*m+8 +: 8]);
		end
		ctl_in.last    = nbr.last_neighbor;
		ctl_in.cig     = nbr.center_in_group;
		ctl_in.base_ok = nbr.center_in_group & nbr.neighbor_valid & nbr.neighbor_in_group;
		ctl_in.col_act = col_act;
		ctl_in.col_win = col_win;
	end

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	ncc_pkg::stage_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;

	logic signed [ncc_pkg::COORD_W:0]     diff_s1 [ncc_pkg::AXES];
	logic        [ncc_pkg::COORD_W:0]     abs_s2  [ncc_pkg::AXES];
	logic        [2*ncc_pkg::COORD_W-1:0] sq_s3   [ncc_pkg::AXES];
	logic                                 over_s3;
	logic        [2*ncc_pkg::COORD_W:0]   sum01_s4;
	logic        [2*ncc_pkg::COORD_W-1:0] sq2_s4;
	logic                                 over_s4;

	logic signed [ncc_pkg::COORD_W-1:0]   cen [ncc_pkg::AXES];
	logic signed [ncc_pkg::COORD_W-1:0]   nb  [ncc_pkg::AXES];
	logic                                 over_s2;

	assign cen[0] = nbr.center_x;
	assign cen[1] = nbr.center_y;
	assign cen[2] = nbr.center_z;
	assign nb[0]  = nbr.neighbor_x;
	assign nb[1]  = nbr.neighbor_y;
	assign nb[2]  = nbr.neighbor_z;

	// hold the whole pipe when its tail cannot enter the queue
	assign adv       = !v_s4 || push_ready;
	assign nbr.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= nbr.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		over_s2 = 1'b0;
		for (int k = 0; k < ncc_pkg::AXES; k++)
			over_s2 = over_s2 | abs_s2[k][ncc_pkg::COORD_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			for (int k = 0; k < ncc_pkg::AXES; k++) begin
				diff_s1[k] <= {cen[k][ncc_pkg::COORD_W-1], cen[k]} -
					{nb[k][ncc_pkg::COORD_W-1], nb[k]};
				abs_s2[k]  <= diff_s1[k][ncc_pkg::COORD_W] ?
					(ncc_pkg::COORD_W+1)'(-diff_s1[k]) : (ncc_pkg::COORD_W+1)'(diff_s1[k]);
				sq_s3[k]   <= abs_s2[k][ncc_pkg::COORD_W-1:0] * abs_s2[k][ncc_pkg::COORD_W-1:0];
			end
			over_s3  <= over_s2;
			sum01_s4 <= {1'b0, sq_s3[0]} + {1'b0, sq_s3[1]};
			sq2_s4   <= sq_s3[2];
			over_s4  <= over_s3;
		end
	end

	logic [2*ncc_pkg::COORD_W+1:0] total;
	logic                          hit;

	always_comb begin
		total = {1'b0, sum01_s4} + {2'b00, sq2_s4};
		hit   = ctl_s4.base_ok && !over_s4 && (total < {2'b00, cutoff_sq_q});
		push_item.last    = ctl_s4.last;
		push_item.cig     = ctl_s4.cig;
		push_item.col_act = ctl_s4.col_act;
		push_item.col_en  = ctl_s4.col_win & ctl_s4.col_act & {ncc_pkg::NUM_OUT{hit}};
	end

	assign push_valid = v_s4;

endmodule

FILE: design/ncc_queue.sv
// Short queue of classified items between the front end and the counter.
`timescale 1ns / 1ps

module ncc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	input  ncc_pkg::q_item_t     push_item,
	output logic                 push_ready,
	output logic                 pop_valid,
	output ncc_pkg::q_item_t     pop_item,
	input  logic                 pop,
	output ncc_pkg::q_stat_t     stat
);

	ncc_pkg::q_item_t            mem_q [ncc_pkg::QUEUE_DEPTH];
	logic [ncc_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [ncc_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [ncc_pkg::QLVL_W-1:0]  level_q;
	logic                        do_push;
	logic                        do_pop;

	assign push_ready = (level_q != ncc_pkg::QLVL_W'(ncc_pkg::QUEUE_DEPTH));
	assign pop_valid  = (level_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	assign stat.level = level_q;
	assign stat.full  = !push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == ncc_pkg::QPTR_W'(ncc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == ncc_pkg::QPTR_W'(ncc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				level_q <= level_q + 1'b1;
			else if (do_pop && !do_push)
				level_q <= level_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

FILE: design/ncc_back.sv
// Back end: saturating per-column counters and the result register.
`timescale 1ns / 1ps

module ncc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  ncc_pkg::q_item_t     item,
	output logic                 pop,
	ncc_out_if.source            res
);

	logic [ncc_pkg::COUNT_W-1:0] counts_q  [ncc_pkg::NUM_OUT];
	logic [ncc_pkg::COUNT_W-1:0] result_q  [ncc_pkg::NUM_OUT];
	logic [ncc_pkg::COUNT_W-1:0] counts_nx [ncc_pkg::NUM_OUT];
	logic                        out_valid_q;
	logic                        out_free;

	assign out_free = !out_valid_q || res.ready;
	assign pop      = item_valid && (!item.last || out_free);

	always_comb begin
		for (int m = 0; m < ncc_pkg::NUM_OUT; m++)
			counts_nx[m] = (item.col_en[m] &&
				counts_q[m] < ncc_pkg::COUNT_W'(ncc_pkg::COUNT_CAP)) ?
				counts_q[m] + 1'b1 : counts_q[m];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int m = 0; m < ncc_pkg::NUM_OUT; m++)
				counts_q[m] <= '0;
		end else begin
			if (pop && item.last)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
			if (pop) begin
				for (int m = 0; m < ncc_pkg::NUM_OUT; m++)
					counts_q[m] <= item.last ? '0 : counts_nx[m];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.last) begin
			for (int m = 0; m < ncc_pkg::NUM_OUT; m++)
				result_q[m] <= (item.cig && item.col_act[m]) ? counts_nx[m] : '0;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.count_col0 = result_q[0];
	assign res.count_col1 = result_q[1];
	assign res.count_col2 = result_q[2];
	assign res.count_col3 = result_q[3];

endmodule

FILE: design/neighbor_coordination_counter_unit.sv
// Top level of the neighbor coordination counter.
//
// Channels: nbr takes one neighbor item per cycle (valid/ready), result gives
// one item of four column counts for each item marked last_neighbor, and cfg
// writes the cutoff, the active column count and the type windows (always ready;
// write only while the block is idle).
// Throughput: one neighbor item per cycle while result.ready keeps up, set by
// the saturating counter update in the back end.
// Path from acceptance of the last neighbor to result.valid high: the four front
// stages (difference, absolute value, squares, partial sum), the final add and
// cutoff compare into the queue, and the counter update into the result
// register.
// A four-entry queue separates the distance pipeline from the counters. When
// result.ready is low, the back end holds at the next last-neighbor item, the
// queue fills, then the front pipeline holds and nbr.ready drops.
// Reset clears all valid state, the running counts and the configuration
// (cutoff 0, one active column, windows 0); no clearing pass is needed.
`timescale 1ns / 1ps

module neighbor_coordination_counter_unit (
	input  logic     clk,
	input  logic     arst_n,
	ncc_in_if.sink   nbr,
	ncc_out_if.source result,
	ncc_cfg_if.sink  cfg
);

	logic               push_valid;
	ncc_pkg::q_item_t   push_item;
	logic               push_ready;
	logic               q_valid;
	ncc_pkg::q_item_t   q_item;
	logic               q_pop;
	ncc_pkg::q_stat_t   q_stat;

	ncc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.nbr        (nbr),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	ncc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_item   (q_item),
		.pop        (q_pop),
		.stat       (q_stat)
	);

	ncc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.pop        (q_pop),
		.res        (result)
	);

	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level <= ncc_pkg::QLVL_W'(ncc_pkg::QUEUE_DEPTH))
		else $error("queue level above depth");

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_valid && q_item.last) |=> result.valid)
		else $error("last neighbor popped without a result");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(q_pop && q_valid && q_item.last))
		else $error("result without a last neighbor");

endmodule
